/* rtl/core/nps_pkg.sv */
// Shared types and codes for the nearest point search block.
package nps_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_FOUND    = 2'd2,
      STATUS_EMPTY    = 2'd3
   } nps_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } nps_state_type;

   // Travels down the distance pipeline next to each point read.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } nps_tag_type;

endpackage

/* rtl/core/nps_point_mem.sv */
// Point table: synchronous memory with one write port and one registered read port.
module nps_point_mem #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 48,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/nps_dist_pipe.sv */
// Three-stage squared-distance pipeline from a stored point to the query point.
module nps_dist_pipe #(
   parameter int CW    = 16,
   parameter int IDX_W = 7,
   parameter int KEY_W = 34
) (
   input  logic                clock,
   input  logic                reset,
   input  nps_pkg::nps_tag_type issue_tag,
   input  logic [IDX_W-1:0]    issue_idx,
   input  logic [3*CW-1:0]     rd_data,
   input  logic [CW-1:0]       query_x,
   input  logic [CW-1:0]       query_y,
   input  logic [CW-1:0]       query_z,
   output nps_pkg::nps_tag_type out_tag,
   output logic [IDX_W-1:0]    out_idx,
   output logic [3*CW-1:0]     out_pt,
   output logic [KEY_W-1:0]    out_key
);
   import nps_pkg::*;

   localparam int MAG_W = CW + 1;
   localparam int SUM_W = 2 * CW + 2;

   nps_tag_type       tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [IDX_W-1:0]  idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [3*CW-1:0]   pt2_ff, pt3_ff, pt4_ff;
   logic [MAG_W-1:0]  mag_x_in, mag_y_in, mag_z_in;
   logic [MAG_W-1:0]  mag_x_ff, mag_y_ff, mag_z_ff;
   logic [SUM_W-1:0]  sq_x_in, sq_y_in, sq_z_in;
   logic [SUM_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W+63:0] sum_ext;
   logic [KEY_W-1:0]  key_in, key4_ff;

   function automatic logic [CW:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic signed [CW:0] d;
      d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
      return d[CW] ? -d : d;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   // Stage 1: per-axis magnitude of the difference, against the registered read data.
   always_comb begin
      mag_x_in = abs_diff(rd_data[CW-1:0], query_x);
      mag_y_in = abs_diff(rd_data[2*CW-1:CW], query_y);
      mag_z_in = abs_diff(rd_data[3*CW-1:2*CW], query_z);
   end

   // Stage 2: squares.
   always_comb begin
      sq_x_in = mag_x_ff * mag_x_ff;
      sq_y_in = mag_y_ff * mag_y_ff;
      sq_z_in = mag_z_ff * mag_z_ff;
   end

   // Stage 3: sum, saturated to 64 bits so that very wide coordinates tie as they should.
   always_comb begin
      sum     = sq_x_ff + sq_y_ff + sq_z_ff;
      sum_ext = {64'b0, sum};
      key_in  = (|sum_ext[SUM_W+63:64]) ? {KEY_W{1'b1}} : sum_ext[KEY_W-1:0];
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= issue_idx;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      idx4_ff  <= idx3_ff;
      pt2_ff   <= rd_data;
      pt3_ff   <= pt2_ff;
      pt4_ff   <= pt3_ff;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      sq_z_ff  <= sq_z_in;
      key4_ff  <= key_in;
   end

   assign out_tag = tag4_ff;
   assign out_idx = idx4_ff;
   assign out_pt  = pt4_ff;
   assign out_key = key4_ff;

endmodule

/* rtl/core/nearest_point_search_3d.sv */
// Top level of the nearest point search: control, best-point tracking and result register.
// Insert, dropped insert or empty query: the result is loaded into the output register from
// the finish state. Query: one stored point is read per cycle while scanning, and the result
// is loaded once the last distance leaves the pipeline; the next transaction waits for that.
// A new transaction is taken while the previous result waits in the output register.
// Reset empties the table (count to zero) at once; the table contents are not cleared.
module nearest_point_search_3d #(
   parameter int MAX_POINTS  = 128,
   parameter int COORD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_pos_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_nearest_index,
   output logic [15:0] rsp_nearest_x,
   output logic [15:0] rsp_nearest_y,
   output logic [15:0] rsp_nearest_z,
   output logic [33:0] rsp_nearest_dist_sq,
   output logic [7:0]  rsp_stored_count
);
   import nps_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = 2 * CW + 2;
   localparam int KEY_W = (SUM_W > 64) ? 64 : SUM_W;
   localparam int PT_W  = 3 * CW;

   nps_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             req_accept, table_full, scan_last, rsp_free, rsp_load;
   nps_tag_type      issue_tag, out_tag;
   logic [IDX_W-1:0] out_idx;
   logic [PT_W-1:0]  out_pt, rd_data, in_pt;
   logic [KEY_W-1:0] out_key;
   logic [CW+15:0]   in_x_ext, in_y_ext, in_z_ext;

   logic [CW-1:0]    query_x_ff, query_y_ff, query_z_ff;
   nps_status_type   status_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [PT_W-1:0]  best_pt_ff;
   logic [KEY_W-1:0] best_key_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [6:0]       rsp_index_ff, rsp_index_in;
   logic [15:0]      rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;
   logic [33:0]      rsp_dist_ff, rsp_dist_in;
   logic [7:0]       rsp_count_ff, rsp_count_in;
   logic [IDX_W+6:0] idx_ext;
   logic [CNT_W+7:0] cnt_ext;
   logic [CW+15:0]   bx_ext, by_ext, bz_ext;
   logic [KEY_W+33:0] key_ext;

   // Coordinates: the low COORD_WIDTH bits of the port, zero-filled when wider.
   always_comb begin
      in_x_ext = {{CW{1'b0}}, req_pos_x};
      in_y_ext = {{CW{1'b0}}, req_pos_y};
      in_z_ext = {{CW{1'b0}}, req_pos_z};
      in_pt    = {in_z_ext[CW-1:0], in_y_ext[CW-1:0], in_x_ext[CW-1:0]};
   end

   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff == CNT_W'(MAX_POINTS));
   assign scan_last  = (CNT_W'(addr_ff) + CNT_W'(1)) == count_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_QUERY && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_tag.valid && out_tag.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      issue_tag.valid = (state_ff == ST_SCAN);
      issue_tag.first = (addr_ff == '0);
      issue_tag.last  = scan_last;
      rsp_load        = (state_ff == ST_FINISH) && rsp_free;
   end

   always_comb begin
      count_in = count_ff;
      addr_in  = addr_ff;
      if (req_accept) begin
         addr_in = '0;
         if (req_operation == OP_INSERT && !table_full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (issue_tag.valid) begin
         addr_in = addr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
      end
   end

   nps_point_mem #(
      .DEPTH  (MAX_POINTS),
      .WIDTH  (PT_W),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (req_accept && req_operation == OP_INSERT && !table_full),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (in_pt),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   nps_dist_pipe #(
      .CW    (CW),
      .IDX_W (IDX_W),
      .KEY_W (KEY_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .issue_idx (addr_ff),
      .rd_data   (rd_data),
      .query_x   (query_x_ff),
      .query_y   (query_y_ff),
      .query_z   (query_z_ff),
      .out_tag   (out_tag),
      .out_idx   (out_idx),
      .out_pt    (out_pt),
      .out_key   (out_key)
   );

   // A later point replaces the best only when strictly closer, so the earliest wins a tie.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         query_x_ff <= in_pt[CW-1:0];
         query_y_ff <= in_pt[2*CW-1:CW];
         query_z_ff <= in_pt[3*CW-1:2*CW];
         best_idx_ff <= '0;
         best_pt_ff  <= '0;
         best_key_ff <= '0;
         if (req_operation == OP_INSERT) begin
            if (table_full) begin
               status_ff <= STATUS_FULL;
            end else begin
               status_ff   <= STATUS_INSERTED;
               best_idx_ff <= count_ff[IDX_W-1:0];
               best_pt_ff  <= in_pt;
            end
         end else if (count_ff == '0) begin
            status_ff <= STATUS_EMPTY;
         end else begin
            status_ff <= STATUS_FOUND;
         end
      end else if (out_tag.valid && (out_tag.first || out_key < best_key_ff)) begin
         best_idx_ff <= out_idx;
         best_pt_ff  <= out_pt;
         best_key_ff <= out_key;
      end
   end

   always_comb begin
      idx_ext      = {7'b0, best_idx_ff};
      cnt_ext      = {8'b0, count_ff};
      bx_ext       = {{16{best_pt_ff[CW-1]}}, best_pt_ff[CW-1:0]};
      by_ext       = {{16{best_pt_ff[2*CW-1]}}, best_pt_ff[2*CW-1:CW]};
      bz_ext       = {{16{best_pt_ff[3*CW-1]}}, best_pt_ff[3*CW-1:2*CW]};
      key_ext      = {34'b0, best_key_ff};
      rsp_index_in = idx_ext[6:0];
      rsp_count_in = cnt_ext[7:0];
      rsp_x_in     = bx_ext[15:0];
      rsp_y_in     = by_ext[15:0];
      rsp_z_in     = bz_ext[15:0];
      rsp_dist_in  = (|key_ext[KEY_W+33:34]) ? {34{1'b1}} : key_ext[33:0];
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= rsp_index_in;
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_z_ff      <= rsp_z_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_nearest_index   = rsp_index_ff;
   assign rsp_nearest_x       = rsp_x_ff;
   assign rsp_nearest_y       = rsp_y_ff;
   assign rsp_nearest_z       = rsp_z_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;
   assign rsp_stored_count    = rsp_count_ff;

`ifndef SYNTH
   // The scan never reads past the last stored point.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CNT_W'(addr_ff) < count_ff)
      else $error("scan address beyond stored points");

   // Distances only come out of the pipeline while a query is in flight.
   a_pipe_in_query: assert property (@(posedge clock) disable iff (reset)
      out_tag.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside a query");

   // An insert into a table with room grows the count by exactly one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == OP_INSERT && !table_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance the point count");

   // A result is loaded only into a free output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_dist_ff))
      else $error("pending result overwritten");
`endif

endmodule
